// ===== sv/lbp_pkg.sv =====
// lbp_pkg: command and status codes and the result record of the buffer pool unit
// no dependencies; imported by lbp_ctrl and lru_buffer_pool_with_generations_unit
`timescale 1ns / 1ps
`default_nettype none

package lbp_pkg;

   localparam int unsigned INDEX_W   = 6;
   localparam int unsigned VERSION_W = 16;
   localparam int unsigned GROW_W    = 7;
   localparam logic [GROW_W-1:0] GROW_RESET = 7'd4;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_PIN     = 2'd2,
      CMD_UNPIN   = 2'd3
   } lbp_cmd_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_NOFREE = 3'd1,
      ST_UNUSED = 3'd2,
      ST_LOST   = 3'd3,
      ST_FULL   = 3'd4
   } lbp_status_type;

   typedef struct packed {
      lbp_status_type         status;
      logic [INDEX_W-1:0]     index;
      logic [VERSION_W-1:0]   version;
   } lbp_rsp_type;

endpackage

`default_nettype wire

// ===== sv/lbp_ram.sv =====
// lbp_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lbp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/lbp_ctrl.sv =====
// lbp_ctrl: sequencer for the recency list, kept as a ring in one ram
// depends on lbp_pkg and lbp_ram
`timescale 1ns / 1ps
`default_nettype none

module lbp_ctrl #(
   parameter int unsigned POOL_BLOCKS  = 64,
   parameter int unsigned VERSION_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire lbp_pkg::lbp_cmd_type            req_cmd,
   input  wire logic [lbp_pkg::INDEX_W-1:0]     req_index,
   input  wire logic [lbp_pkg::VERSION_W-1:0]   req_version,
   input  wire logic [lbp_pkg::GROW_W-1:0]      grow_step,
   output logic                                 res_valid,
   input  wire logic                            res_ready,
   output lbp_pkg::lbp_rsp_type                 res
);
   import lbp_pkg::*;

   localparam int unsigned IDX_W = $clog2(POOL_BLOCKS);
   localparam int unsigned CNT_W = $clog2(POOL_BLOCKS + 1);
   localparam int unsigned VER_W = VERSION_BITS;
   localparam int unsigned ENT_W = VER_W + IDX_W;
   localparam logic [CNT_W-1:0] N_CNT  = CNT_W'(POOL_BLOCKS);
   localparam logic [IDX_W:0]   N_WRAP = (IDX_W + 1)'(POOL_BLOCKS);
   localparam logic [IDX_W-1:0] LAST   = IDX_W'(POOL_BLOCKS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_GROW,
      S_ALLOC_WR,
      S_SEARCH,
      S_SHIFT,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   lbp_cmd_type          cmd_ff, cmd_in;
   logic [IDX_W-1:0]     hidx_ff, hidx_in;
   logic [VER_W-1:0]     hver_ff, hver_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     lim_ff, lim_in;
   logic                 pend_v_ff, pend_v_in;
   logic [IDX_W-1:0]     pend_pos_ff, pend_pos_in;
   logic [IDX_W-1:0]     sh_pos_ff, sh_pos_in;
   lbp_rsp_type          rsp_ff, rsp_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_wa;
   logic [ENT_W-1:0]     ram_wd;
   logic [IDX_W-1:0]     ram_ra;
   logic [ENT_W-1:0]     ram_rd;
   logic                 rd_issue;

   logic [IDX_W-1:0]     head_dec;
   logic [IDX_W-1:0]     head_inc;
   logic [GROW_W-1:0]    step_w;
   logic [CNT_W-1:0]     avail;
   logic [CNT_W-1:0]     grow_k;
   logic                 hit;
   logic [VER_W-1:0]     next_ver;

   // logical list position to ram address
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [IDX_W-1:0] lg);
      logic [IDX_W:0] s;
      s = {1'b0, base} + {1'b0, lg};
      if (s >= N_WRAP) begin
         s = s - N_WRAP;
      end
      return s[IDX_W-1:0];
   endfunction

   lbp_ram #(
      .WIDTH (ENT_W),
      .DEPTH (POOL_BLOCKS)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign head_dec = (head_ff == '0) ? LAST : head_ff - 1'b1;
   assign head_inc = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   assign step_w   = (grow_step == '0) ? GROW_W'(1) : grow_step;
   assign avail    = N_CNT - used_ff;
   assign grow_k   = (32'(step_w) < 32'(avail)) ? CNT_W'(32'(step_w)) : avail;
   assign hit      = pend_v_ff && (ram_rd[IDX_W-1:0] == hidx_ff) &&
                     (ram_rd[ENT_W-1:IDX_W] == hver_ff);
   assign next_ver = ram_rd[ENT_W-1:IDX_W] + 1'b1;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      len_in      = len_ff;
      used_in     = used_ff;
      cmd_in      = cmd_ff;
      hidx_in     = hidx_ff;
      hver_in     = hver_ff;
      cnt_in      = cnt_ff;
      lim_in      = lim_ff;
      pend_v_in   = pend_v_ff;
      pend_pos_in = pend_pos_ff;
      sh_pos_in   = sh_pos_ff;
      rsp_in      = rsp_ff;
      ram_we      = 1'b0;
      ram_wa      = '0;
      ram_wd      = '0;
      ram_ra      = '0;
      rd_issue    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in         = req_cmd;
               hidx_in        = IDX_W'(32'(req_index));
               hver_in        = VER_W'(32'(req_version));
               rsp_in.status  = ST_OK;
               rsp_in.index   = '0;
               rsp_in.version = '0;
               if (req_cmd == CMD_ALLOC) begin
                  if (len_ff == '0) begin
                     if (used_ff >= N_CNT) begin
                        rsp_in.status = ST_NOFREE;
                        state_in      = S_DONE;
                     end else begin
                        lim_in         = grow_k;
                        cnt_in         = '0;
                        rsp_in.index   = INDEX_W'(32'(used_ff + grow_k - 1'b1));
                        rsp_in.version = VERSION_W'(1);
                        state_in       = S_GROW;
                     end
                  end else begin
                     rd_issue = 1'b1;
                     ram_ra   = phys(head_ff, IDX_W'(len_ff - 1'b1));
                     state_in = S_ALLOC_WR;
                  end
               end else if (32'(req_index) >= 32'(used_ff)) begin
                  rsp_in.status = ST_UNUSED;
                  state_in      = S_DONE;
               end else if (req_cmd == CMD_UNPIN) begin
                  if (len_ff >= N_CNT) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     ram_we  = 1'b1;
                     ram_wa  = head_dec;
                     ram_wd  = {VER_W'(32'(req_version)), IDX_W'(32'(req_index))};
                     head_in = head_dec;
                     len_in  = len_ff + 1'b1;
                  end
                  state_in = S_DONE;
               end else if (len_ff == '0) begin
                  rsp_in.status = (req_cmd == CMD_PIN) ? ST_LOST : ST_OK;
                  state_in      = S_DONE;
               end else begin
                  cnt_in    = '0;
                  pend_v_in = 1'b0;
                  state_in  = S_SEARCH;
               end
            end
         end

         // fresh indices, the last one goes to the front with generation one
         S_GROW: begin
            ram_we = 1'b1;
            ram_wa = phys(head_ff, IDX_W'(cnt_ff));
            if (cnt_ff == '0) begin
               ram_wd = {VER_W'(1), IDX_W'(used_ff + lim_ff - 1'b1)};
            end else begin
               ram_wd = {VER_W'(0), IDX_W'(used_ff + cnt_ff - 1'b1)};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lim_ff - 1'b1) begin
               used_in  = used_ff + lim_ff;
               len_in   = lim_ff;
               state_in = S_DONE;
            end
         end

         S_ALLOC_WR: begin
            ram_we         = 1'b1;
            ram_wa         = head_dec;
            ram_wd         = {next_ver, ram_rd[IDX_W-1:0]};
            head_in        = head_dec;
            rsp_in.index   = INDEX_W'(32'(ram_rd[IDX_W-1:0]));
            rsp_in.version = VERSION_W'(32'(next_ver));
            state_in       = S_DONE;
         end

         S_SEARCH: begin
            if (hit) begin
               pend_v_in = 1'b0;
               if (pend_pos_ff == '0) begin
                  if (cmd_ff == CMD_PIN) begin
                     head_in = head_inc;
                     len_in  = len_ff - 1'b1;
                  end
                  state_in = S_DONE;
               end else begin
                  cnt_in    = CNT_W'(pend_pos_ff);
                  sh_pos_in = pend_pos_ff - 1'b1;
                  state_in  = S_SHIFT;
               end
            end else if (cnt_ff < len_ff) begin
               rd_issue    = 1'b1;
               ram_ra      = phys(head_ff, IDX_W'(cnt_ff));
               pend_v_in   = 1'b1;
               pend_pos_in = IDX_W'(cnt_ff);
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               pend_v_in     = 1'b0;
               rsp_in.status = (cmd_ff == CMD_PIN) ? ST_LOST : ST_OK;
               state_in      = S_DONE;
            end
         end

         // move entries ahead of the match one place toward the back
         S_SHIFT: begin
            if (pend_v_ff) begin
               ram_we = 1'b1;
               ram_wa = phys(head_ff, pend_pos_ff);
               ram_wd = ram_rd;
            end
            if (cnt_ff != '0) begin
               rd_issue    = 1'b1;
               ram_ra      = phys(head_ff, sh_pos_ff);
               pend_v_in   = 1'b1;
               pend_pos_in = sh_pos_ff + 1'b1;
               sh_pos_in   = sh_pos_ff - 1'b1;
               cnt_in      = cnt_ff - 1'b1;
            end else begin
               pend_v_in = 1'b0;
               if (!pend_v_ff) begin
                  if (cmd_ff == CMD_PIN) begin
                     head_in = head_inc;
                     len_in  = len_ff - 1'b1;
                  end else begin
                     ram_we = 1'b1;
                     ram_wa = head_ff;
                     ram_wd = {hver_ff, hidx_ff};
                  end
                  state_in = S_DONE;
               end
            end
         end

         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         len_ff    <= '0;
         used_ff   <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         len_ff    <= len_in;
         used_ff   <= used_in;
         pend_v_ff <= pend_v_in;
      end
      cmd_ff      <= cmd_in;
      hidx_ff     <= hidx_in;
      hver_ff     <= hver_in;
      cnt_ff      <= cnt_in;
      lim_ff      <= lim_in;
      pend_pos_ff <= pend_pos_in;
      sh_pos_ff   <= sh_pos_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = rsp_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= N_CNT)
      else $error("list length above pool size");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= N_CNT)
      else $error("used count above pool size");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      32'(head_ff) < POOL_BLOCKS)
      else $error("head pointer out of range");

   a_no_collide: assert property (@(posedge clock) disable iff (reset)
      (ram_we && rd_issue) |-> (ram_wa != ram_ra))
      else $error("read and write to the same entry in one cycle");

endmodule

`default_nettype wire

// ===== sv/lru_buffer_pool_with_generations_unit.sv =====
// allocate: the tail entry moves to the front with its generation raised by one, or,
//   with an empty list, fresh indices are added. release / pin: search from the front,
//   then shift of the entries ahead of the match (one ram read port per cycle); unpin
//   writes the entry to the front. one transaction in work at a time; the next is taken
//   while a result waits in the output register. synchronous reset empties the list,
//   clears the used count and sets grow_step to 4; the list ram needs no clearing
`timescale 1ns / 1ps
`default_nettype none

module lru_buffer_pool_with_generations_unit #(
   parameter int unsigned POOL_BLOCKS  = 64,
   parameter int unsigned VERSION_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // handle_index, handle_version, zero fill
   input  wire logic [1:0]  req_tuser,   // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // out_index, out_version, zero fill
   output logic [2:0]       rsp_tuser,   // status
   input  wire logic        csr_wen,
   input  wire logic [6:0]  csr_wdata
);
   import lbp_pkg::*;

   logic [GROW_W-1:0] grow_ff;
   logic              res_valid;
   logic              res_ready;
   lbp_rsp_type       res;
   logic              rsp_valid_ff;
   lbp_rsp_type       rsp_ff;

   lbp_ctrl #(
      .POOL_BLOCKS  (POOL_BLOCKS),
      .VERSION_BITS (VERSION_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (lbp_cmd_type'(req_tuser)),
      .req_index   (req_tdata[5:0]),
      .req_version (req_tdata[21:6]),
      .grow_step   (grow_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grow_ff      <= GROW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            grow_ff <= csr_wdata;
         end
         if (res_ready) begin
            rsp_valid_ff <= res_valid;
         end
      end
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.version, rsp_ff.index};
   assign rsp_tuser  = rsp_ff.status;

endmodule

`default_nettype wire
